// File: sv/bctd_pkg.sv
`timescale 1ns / 1ps

package bctd_pkg;

    // Block format register codes
    typedef enum logic [1:0] {
        FMT_DXT1 = 2'd0,
        FMT_DXT3 = 2'd1,
        FMT_DXT5 = 2'd2,
        FMT_BC5  = 2'd3
    } fmt_t;

    localparam logic [7:0] BYTE_FULL = 8'd255;
    localparam logic [7:0] BC5_FILL  = 8'd127;
    localparam logic [3:0] PIX_LAST  = 4'd15;
    localparam int         COORD_W   = 14;

    typedef struct packed {
        logic [63:0] word_lo;
        logic [63:0] word_hi;
        logic [11:0] block_col;
        logic [11:0] block_row;
    } in_item_t;

    typedef struct packed {
        logic [COORD_W-1:0] pix_x;
        logic [COORD_W-1:0] pix_y;
        logic [7:0]         out_blue;
        logic [7:0]         out_green;
        logic [7:0]         out_red;
        logic [7:0]         out_alpha;
        logic               last_pixel;
    } out_item_t;

    // Replicate the top bits to widen a 5- or 6-bit colour field to 8 bits
    function automatic logic [7:0] widen5(input logic [4:0] v);
        return {v, v[4:2]};
    endfunction

    function automatic logic [7:0] widen6(input logic [5:0] v);
        return {v, v[5:4]};
    endfunction

    // Exact division by reciprocal multiply over the ranges used here
    // (x/3 for x <= 765, x/5 for x <= 1275, x/7 for x <= 1785)
    function automatic logic [7:0] div3(input logic [10:0] x);
        logic [21:0] p;
        p = 22'(x) * 22'd683;
        return p[18:11];
    endfunction

    function automatic logic [7:0] div5(input logic [10:0] x);
        logic [23:0] p;
        p = 24'(x) * 24'd1639;
        return p[20:13];
    endfunction

    function automatic logic [7:0] div7(input logic [10:0] x);
        logic [24:0] p;
        p = 25'(x) * 25'd2341;
        return p[21:14];
    endfunction

endpackage

// File: sv/block_compressed_texture_decoder_unit.sv
`timescale 1ns / 1ps

// Compressed texture block decoder for the DXT1, DXT3, DXT5 and BC5
// two-channel formats. Each input transfer carries one 4x4 block (two
// little-endian 64-bit words) and its block column and row; the unit returns
// sixteen output transfers, one pixel each, in row-major order, with image
// coordinates, BGRA bytes and last_pixel on the sixteenth. The format register
// is written through cfg_we/cfg_wdata and must only change while the unit is
// idle; it is sampled when a block is taken. A block passes an input register,
// an endpoint/weighted-sum stage and a palette stage, then a pixel sequencer
// reads one pixel per cycle out of the palette stage into the output register
// while out_stall is low; the palette stage holds the block until its sixteenth
// pixel is handed on. Up to two further blocks queue in the earlier stages,
// so in_stall rises only when those are all occupied. Block indices wrap at
// 2^BLOCK_INDEX_BITS and pixel coordinates at 2^14.
module block_compressed_texture_decoder_unit
    import bctd_pkg::*;
#(
    parameter int BLOCK_INDEX_BITS = 12
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [1:0] cfg_wdata,
    input  logic       in_valid,
    output logic       in_stall,
    input  in_item_t   in_data,
    output logic       out_valid,
    input  logic       out_stall,
    output out_item_t  out_data
);

    localparam int BI = BLOCK_INDEX_BITS;

    // ------------------------------------------------------------------
    // Format register
    // ------------------------------------------------------------------
    fmt_t fmt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg <= FMT_DXT1;
        end
        else if (cfg_we)
        begin
            fmt_reg <= fmt_t'(cfg_wdata);
        end
    end

    // ------------------------------------------------------------------
    // Flow control: a stage loads when it is empty or its content leaves
    // ------------------------------------------------------------------
    logic       s1_valid_reg, s2_valid_reg, s3_valid_reg, out_valid_reg;
    logic [3:0] cnt_reg;
    logic       out_adv, s3_ld, s2_ld, s1_ld;

    assign out_adv  = !out_valid_reg || !out_stall;
    assign s3_ld    = !s3_valid_reg || (out_adv && (cnt_reg == PIX_LAST));
    assign s2_ld    = !s2_valid_reg || s3_ld;
    assign s1_ld    = !s1_valid_reg || s2_ld;
    assign in_stall = !s1_ld;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            if (s1_ld)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s2_ld)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_ld)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (out_adv)
            begin
                out_valid_reg <= s3_valid_reg;
            end
            // Advance the pixel counter on every pixel handed on; it wraps
            // to zero as the block leaves the palette stage.
            if (s3_valid_reg && out_adv)
            begin
                cnt_reg <= cnt_reg + 4'd1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: input register
    // ------------------------------------------------------------------
    logic [63:0]  s1_lo_reg, s1_hi_reg;
    logic [BI-1:0] s1_col_reg, s1_row_reg;
    fmt_t         s1_fmt_reg;
    logic [13:0]  col_ext, row_ext;

    // Zero-extend so that any index width up to fourteen bits can be cut out
    assign col_ext = 14'(in_data.block_col);
    assign row_ext = 14'(in_data.block_row);

    always_ff @(posedge clk)
    begin
        if (s1_ld)
        begin
            s1_lo_reg  <= in_data.word_lo;
            s1_hi_reg  <= in_data.word_hi;
            s1_col_reg <= col_ext[BI-1:0];
            s1_row_reg <= row_ext[BI-1:0];
            s1_fmt_reg <= fmt_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: colour endpoints and weighted sums for the interpolators
    // ------------------------------------------------------------------
    logic [63:0]  s1_cw;
    logic [15:0]  c0, c1;
    logic [7:0]   ep0_next [3];
    logic [7:0]   ep1_next [3];
    logic [10:0]  n2_next  [3];
    logic [10:0]  n3_next  [3];
    logic         four_next;
    logic [63:0]  s1_chw   [2];
    logic         gt_next  [2];
    logic [10:0]  n7_next  [2][6];
    logic [10:0]  n5_next  [2][4];

    always_comb
    begin
        s1_cw = (s1_fmt_reg == FMT_DXT1) ? s1_lo_reg : s1_hi_reg;
        c0    = s1_cw[15:0];
        c1    = s1_cw[31:16];

        ep0_next[0] = widen5(c0[4:0]);
        ep0_next[1] = widen6(c0[10:5]);
        ep0_next[2] = widen5(c0[15:11]);
        ep1_next[0] = widen5(c1[4:0]);
        ep1_next[1] = widen6(c1[10:5]);
        ep1_next[2] = widen5(c1[15:11]);

        for (int ch = 0; ch < 3; ch++)
        begin
            n2_next[ch] = {2'b0, ep0_next[ch], 1'b0} + {3'b0, ep1_next[ch]};
            n3_next[ch] = {3'b0, ep0_next[ch]} + {2'b0, ep1_next[ch], 1'b0};
        end

        // Three-colour mode exists only for DXT1 with c0 <= c1
        four_next = (c0 > c1) || (s1_fmt_reg != FMT_DXT1);

        s1_chw[0] = s1_lo_reg;
        s1_chw[1] = s1_hi_reg;
        for (int c = 0; c < 2; c++)
        begin
            gt_next[c] = s1_chw[c][7:0] > s1_chw[c][15:8];
            for (int j = 0; j < 6; j++)
            begin
                n7_next[c][j] = 11'(6 - j) * {3'b0, s1_chw[c][7:0]}
                              + 11'(j + 1) * {3'b0, s1_chw[c][15:8]};
            end
            for (int j = 0; j < 4; j++)
            begin
                n5_next[c][j] = 11'(4 - j) * {3'b0, s1_chw[c][7:0]}
                              + 11'(j + 1) * {3'b0, s1_chw[c][15:8]};
            end
        end
    end

    logic [63:0]   s2_lo_reg, s2_hi_reg;
    logic [BI-1:0] s2_col_reg, s2_row_reg;
    fmt_t          s2_fmt_reg;
    logic [7:0]    s2_ep0_reg [3];
    logic [7:0]    s2_ep1_reg [3];
    logic [10:0]   s2_n2_reg  [3];
    logic [10:0]   s2_n3_reg  [3];
    logic          s2_four_reg;
    logic          s2_gt_reg  [2];
    logic [10:0]   s2_n7_reg  [2][6];
    logic [10:0]   s2_n5_reg  [2][4];

    always_ff @(posedge clk)
    begin
        if (s2_ld)
        begin
            s2_lo_reg   <= s1_lo_reg;
            s2_hi_reg   <= s1_hi_reg;
            s2_col_reg  <= s1_col_reg;
            s2_row_reg  <= s1_row_reg;
            s2_fmt_reg  <= s1_fmt_reg;
            s2_ep0_reg  <= ep0_next;
            s2_ep1_reg  <= ep1_next;
            s2_n2_reg   <= n2_next;
            s2_n3_reg   <= n3_next;
            s2_four_reg <= four_next;
            s2_gt_reg   <= gt_next;
            s2_n7_reg   <= n7_next;
            s2_n5_reg   <= n5_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: colour palette and the two eight-entry channel tables
    // ------------------------------------------------------------------
    logic [7:0] pal_next [4][4];   // [entry][B,G,R,A]
    logic [7:0] tab_next [2][8];   // [lo/hi word][entry]
    logic [8:0] avg_sum  [3];
    logic [63:0] s2_chw  [2];

    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            avg_sum[ch]     = {1'b0, s2_ep0_reg[ch]} + {1'b0, s2_ep1_reg[ch]};
            pal_next[0][ch] = s2_ep0_reg[ch];
            pal_next[1][ch] = s2_ep1_reg[ch];
            pal_next[2][ch] = s2_four_reg ? div3(s2_n2_reg[ch]) : avg_sum[ch][8:1];
            pal_next[3][ch] = s2_four_reg ? div3(s2_n3_reg[ch]) : 8'd0;
        end
        pal_next[0][3] = BYTE_FULL;
        pal_next[1][3] = BYTE_FULL;
        pal_next[2][3] = BYTE_FULL;
        // Transparent black in three-colour mode
        pal_next[3][3] = s2_four_reg ? BYTE_FULL : 8'd0;

        s2_chw[0] = s2_lo_reg;
        s2_chw[1] = s2_hi_reg;
        for (int c = 0; c < 2; c++)
        begin
            tab_next[c][0] = s2_chw[c][7:0];
            tab_next[c][1] = s2_chw[c][15:8];
            if (s2_gt_reg[c])
            begin
                for (int j = 0; j < 6; j++)
                begin
                    tab_next[c][j + 2] = div7(s2_n7_reg[c][j]);
                end
            end
            else
            begin
                for (int j = 0; j < 4; j++)
                begin
                    tab_next[c][j + 2] = div5(s2_n5_reg[c][j]);
                end
                tab_next[c][6] = 8'd0;
                tab_next[c][7] = BYTE_FULL;
            end
        end
    end

    logic [63:0]   s3_lo_reg, s3_hi_reg;
    logic [BI-1:0] s3_col_reg, s3_row_reg;
    fmt_t          s3_fmt_reg;
    logic [7:0]    s3_pal_reg [4][4];
    logic [7:0]    s3_tab_reg [2][8];

    always_ff @(posedge clk)
    begin
        if (s3_ld)
        begin
            s3_lo_reg  <= s2_lo_reg;
            s3_hi_reg  <= s2_hi_reg;
            s3_col_reg <= s2_col_reg;
            s3_row_reg <= s2_row_reg;
            s3_fmt_reg <= s2_fmt_reg;
            s3_pal_reg <= pal_next;
            s3_tab_reg <= tab_next;
        end
    end

    // ------------------------------------------------------------------
    // Pixel sequencer: pick pixel cnt_reg out of the held block
    // ------------------------------------------------------------------
    logic [31:0]      cidx;
    logic [1:0]       ci;
    logic [47:0]      lo_idx, hi_idx;
    logic [5:0]       pos3;
    logic [2:0]       ai_lo, ai_hi;
    logic [3:0]       nib;
    logic [BI+15:0]   px_wide, py_wide;
    out_item_t        pix_next;
    out_item_t        out_reg;

    always_comb
    begin
        cidx   = (s3_fmt_reg == FMT_DXT1) ? s3_lo_reg[63:32] : s3_hi_reg[63:32];
        ci     = cidx[{cnt_reg, 1'b0} +: 2];
        lo_idx = s3_lo_reg[63:16];
        hi_idx = s3_hi_reg[63:16];
        pos3   = {1'b0, cnt_reg, 1'b0} + {2'b0, cnt_reg};
        ai_lo  = lo_idx[pos3 +: 3];
        ai_hi  = hi_idx[pos3 +: 3];
        nib    = s3_lo_reg[{cnt_reg, 2'b00} +: 4];

        px_wide = {14'd0, s3_col_reg, cnt_reg[1:0]};
        py_wide = {14'd0, s3_row_reg, cnt_reg[3:2]};

        pix_next.pix_x      = px_wide[COORD_W-1:0];
        pix_next.pix_y      = py_wide[COORD_W-1:0];
        pix_next.last_pixel = (cnt_reg == PIX_LAST);
        pix_next.out_blue   = s3_pal_reg[ci][0];
        pix_next.out_green  = s3_pal_reg[ci][1];
        pix_next.out_red    = s3_pal_reg[ci][2];
        pix_next.out_alpha  = s3_pal_reg[ci][3];

        case (s3_fmt_reg)
            FMT_BC5:
            begin
                pix_next.out_blue  = s3_tab_reg[0][ai_lo];
                pix_next.out_green = s3_tab_reg[1][ai_hi];
                pix_next.out_red   = BC5_FILL;
                pix_next.out_alpha = BYTE_FULL;
            end
            FMT_DXT3:
            begin
                // Four-bit alpha times 17 is the nibble repeated
                pix_next.out_alpha = {nib, nib};
            end
            FMT_DXT5:
            begin
                pix_next.out_alpha = s3_tab_reg[0][ai_lo];
            end
            default:
            begin
                pix_next.out_alpha = s3_pal_reg[ci][3];
            end
        endcase
    end

    // Output register: hold the pixel while the far side stalls
    always_ff @(posedge clk)
    begin
        if (out_adv)
        begin
            out_reg <= pix_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// File: test/tb_block_compressed_texture_decoder_unit.sv
`timescale 1ns / 1ps

module tb_block_compressed_texture_decoder_unit;
    import bctd_pkg::*;

    localparam int CLK_HALF         = 4;
    localparam int RESET_CYCLES     = 5;
    localparam int RANDOM_PHASES    = 8;
    localparam int BLOCKS_PER_PHASE = 50;
    // Idle time after the drain to catch stray pixels; allow ample margin
    localparam int DRAIN_CYCLES     = 32;
    localparam int ALPHA4_SCALE     = 17;
    localparam int COORD_MASK       = (1 << COORD_W) - 1;

    // One directed block: format, payload and, where the colour of every
    // pixel is obvious, the BGRA value pinned by hand as {b, g, r, a}
    typedef struct packed {
        fmt_t        fmt;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [11:0] col;
        logic [11:0] row;
        logic        pinned;
        logic [31:0] bgra;
    } plan_row_t;

    localparam int PLAN_LEN = 19;
    localparam plan_row_t PLAN [PLAN_LEN] = '{
        // DXT1 straight after reset, equal black endpoints: three-colour mode, index 0
        '{FMT_DXT1, 64'h0, 64'h0, 12'd0, 12'd0, 1'b1, 32'h000000FF},
        // DXT1 equal white endpoints, every index 3: transparent black at the far corner
        '{FMT_DXT1, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 12'd4095, 12'd4095, 1'b1, 32'h00000000},
        // DXT1 four-colour mode (c0 > c1), all four indices
        '{FMT_DXT1, 64'hE4E4_E4E4_0000_FFFF, 64'h0, 12'd1, 12'd2, 1'b0, 32'h0},
        // DXT1 three-colour mode (c0 < c1); upper word is junk and must be ignored
        '{FMT_DXT1, 64'h1B1B_1B1B_F800_001F, 64'hFFFF_FFFF_FFFF_FFFF, 12'd4095, 12'd0,
          1'b0, 32'h0},
        // DXT1 equal non-zero endpoints: average entry and transparent black
        '{FMT_DXT1, 64'hE4E4_E4E4_07E0_07E0, 64'h5A5A_A5A5_5A5A_A5A5, 12'd0, 12'd4095,
          1'b0, 32'h0},
        // DXT3 full explicit alpha over black
        '{FMT_DXT3, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 12'd7, 12'd9, 1'b1, 32'h000000FF},
        // DXT3 keeps four-colour mode with equal endpoints: index 3 is white, alpha zero
        '{FMT_DXT3, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 12'd4095, 12'd4095, 1'b1, 32'hFFFFFF00},
        // DXT3 alpha ramp across all sixteen nibble values, c0 < c1
        '{FMT_DXT3, 64'hFEDC_BA98_7654_3210, 64'hE4E4_E4E4_F800_001F, 12'd100, 12'd200,
          1'b0, 32'h0},
        '{FMT_DXT3, 64'h0123_4567_89AB_CDEF, 64'h1B1B_1B1B_001F_F800, 12'd2048, 12'd2047,
          1'b0, 32'h0},
        // DXT5 eight-entry alpha (e0 > e1), every 3-bit index
        '{FMT_DXT5, 64'hFAC6_88FA_C688_00FF, 64'hE4E4_E4E4_07FF_F81F, 12'd3, 12'd5,
          1'b0, 32'h0},
        // DXT5 six-entry alpha with 0 and 255 (e0 < e1), c0 < c1 still four-colour
        '{FMT_DXT5, 64'hFAC6_88FA_C688_FF00, 64'h1B1B_1B1B_FFFF_0000, 12'd4095, 12'd1,
          1'b0, 32'h0},
        // DXT5 equal alpha endpoints
        '{FMT_DXT5, 64'h0588_FA05_88FA_4040, 64'h36C9_9C63_8410_8410, 12'd1, 12'd4095,
          1'b0, 32'h0},
        '{FMT_DXT5, 64'h0, 64'h0, 12'd0, 12'd0, 1'b1, 32'h00000000},
        '{FMT_DXT5, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 12'd4095, 12'd4095,
          1'b1, 32'hFFFFFFFF},
        // Two-channel: first channel e0 > e1, second e0 < e1
        '{FMT_BC5, 64'hFAC6_88FA_C688_10F0, 64'hFAC6_88FA_C688_F010, 12'd10, 12'd11,
          1'b0, 32'h0},
        '{FMT_BC5, 64'h88FA_C688_FAC6_3030, 64'hC688_FAC6_88FA_00FF, 12'd4094, 12'd4093,
          1'b0, 32'h0},
        '{FMT_BC5, 64'h0, 64'h0, 12'd0, 12'd0, 1'b1, 32'h00007FFF},
        '{FMT_BC5, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 12'd4095, 12'd4095,
          1'b1, 32'hFFFF7FFF},
        // Back to DXT1 after the two-channel format
        '{FMT_DXT1, 64'hE4E4_E4E4_0000_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 12'd2048, 12'd1,
          1'b0, 32'h0}
    };

    logic      clk;
    logic      rst_n;
    logic      cfg_we;
    logic [1:0] cfg_wdata;
    logic      in_valid;
    logic      in_stall;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_stall;
    out_item_t out_data;

    // Shadow of the format register, updated on each write
    fmt_t      fmt_shadow;
    // Pixels still owed by the unit, oldest first
    out_item_t pending_pixels [$];
    // Hand-pinned colour travelling with the block on the input channel
    logic      pin_on;
    logic [31:0] pin_bgra;
    bit        tx_calm;

    int mismatch_count;
    int blocks_taken;
    int pixels_checked;
    int fmt_blocks [4];

    block_compressed_texture_decoder_unit #(
        .BLOCK_INDEX_BITS(12)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // Interpolated 8-entry table for DXT5 alpha and each two-channel half
    function automatic void build_ramp(input logic [63:0] w, output int t[8]);
        int e0;
        int e1;
        e0 = w[7:0];
        e1 = w[15:8];
        t[0] = e0;
        t[1] = e1;
        if (e0 > e1)
        begin
            for (int k = 1; k <= 6; k++)
                t[1 + k] = ((7 - k) * e0 + k * e1) / 7;
        end
        else
        begin
            for (int k = 1; k <= 4; k++)
                t[1 + k] = ((5 - k) * e0 + k * e1) / 5;
            t[6] = 0;
            t[7] = 255;
        end
    endfunction

    // Expand one accepted block into its sixteen pixels and queue them
    function automatic void decode_block(fmt_t f, in_item_t blk, logic pinned,
                                         logic [31:0] bgra);
        logic [63:0] cw;
        int          c0;
        int          c1;
        int          v;
        int          ends [2][3];
        int          pal [4][4];
        int          ta [8];
        int          tb [8];
        bit          four;
        int          ci;
        out_item_t   px;
        cw = (f == FMT_DXT1) ? blk.word_lo : blk.word_hi;
        c0 = cw[15:0];
        c1 = cw[31:16];
        // Three-colour mode only for DXT1 with c0 <= c1
        four = (c0 > c1) || (f != FMT_DXT1);
        for (int e = 0; e < 2; e++)
        begin
            v = (e == 0) ? c0 : c1;
            ends[e][0] = ((v & 31) << 3) | ((v & 31) >> 2);
            ends[e][1] = (((v >> 5) & 63) << 2) | (((v >> 5) & 63) >> 4);
            ends[e][2] = (((v >> 11) & 31) << 3) | (((v >> 11) & 31) >> 2);
        end
        for (int ch = 0; ch < 3; ch++)
        begin
            pal[0][ch] = ends[0][ch];
            pal[1][ch] = ends[1][ch];
            pal[2][ch] = four ? (2 * ends[0][ch] + ends[1][ch]) / 3
                              : (ends[0][ch] + ends[1][ch]) / 2;
            pal[3][ch] = four ? (ends[0][ch] + 2 * ends[1][ch]) / 3 : 0;
        end
        pal[0][3] = 255;
        pal[1][3] = 255;
        pal[2][3] = 255;
        pal[3][3] = four ? 255 : 0;
        build_ramp(blk.word_lo, ta);
        build_ramp(blk.word_hi, tb);

        for (int i = 0; i < 16; i++)
        begin
            if (f == FMT_BC5)
            begin
                px.out_blue  = 8'(ta[blk.word_lo[16 + 3 * i +: 3]]);
                px.out_green = 8'(tb[blk.word_hi[16 + 3 * i +: 3]]);
                px.out_red   = BC5_FILL;
                px.out_alpha = BYTE_FULL;
            end
            else
            begin
                ci = cw[32 + 2 * i +: 2];
                px.out_blue  = 8'(pal[ci][0]);
                px.out_green = 8'(pal[ci][1]);
                px.out_red   = 8'(pal[ci][2]);
                px.out_alpha = 8'(pal[ci][3]);
                if (f == FMT_DXT3)
                    px.out_alpha = 8'(int'(blk.word_lo[4 * i +: 4]) * ALPHA4_SCALE);
                else if (f == FMT_DXT5)
                    px.out_alpha = 8'(ta[blk.word_lo[16 + 3 * i +: 3]]);
            end
            if (pinned)
                {px.out_blue, px.out_green, px.out_red, px.out_alpha} = bgra;
            px.pix_x      = COORD_W'((int'(blk.block_col) * 4 + (i & 3)) & COORD_MASK);
            px.pix_y      = COORD_W'((int'(blk.block_row) * 4 + (i >> 2)) & COORD_MASK);
            px.last_pixel = (i == 15);
            pending_pixels.push_back(px);
        end
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    // Tie endpoints together now and then so the equal cases turn up often
    function automatic logic [63:0] shape_word(logic [63:0] w);
        logic [63:0] s;
        s = w;
        case ($urandom_range(0, 4))
            0: s[31:16] = s[15:0];
            1: s[15:8]  = s[7:0];
            default: ;
        endcase
        return s;
    endfunction

    function automatic logic [11:0] random_index();
        case ($urandom_range(0, 7))
            0: return 12'd0;
            1: return 12'd4095;
            default: return 12'($urandom_range(0, 4095));
        endcase
    endfunction

    function automatic in_item_t random_block();
        in_item_t blk;
        blk.word_lo   = shape_word({$urandom, $urandom});
        blk.word_hi   = shape_word({$urandom, $urandom});
        blk.block_col = random_index();
        blk.block_row = random_index();
        return blk;
    endfunction

    // Present one block after a random gap and hold it until the transfer
    task automatic send_block(in_item_t blk, logic pinned, logic [31:0] bgra);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 3);
        repeat (gap)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            @(posedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_data  <= blk;
        pin_on   <= pinned;
        pin_bgra <= bgra;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Drop valid, drain every owed pixel, then write the format register
    task automatic write_format(fmt_t f);
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= f;
        @(posedge clk);
        fmt_shadow = f;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Scoreboard: queue the pixels of each block at its transfer, then
    // compare every pixel transfer against the oldest owed pixel
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                decode_block(fmt_shadow, in_data, pin_on, pin_bgra);
                blocks_taken++;
                fmt_blocks[fmt_shadow]++;
            end
            if (out_valid && !out_stall)
            begin
                pixels_checked++;
                if (pending_pixels.size() == 0)
                begin
                    $display("%0t ns: unexpected pixel, expected none, got %p", $time, out_data);
                    mismatch_count++;
                end
                else
                begin
                    want = pending_pixels.pop_front();
                    check_field("pix_x",      want.pix_x,      out_data.pix_x);
                    check_field("pix_y",      want.pix_y,      out_data.pix_y);
                    check_field("out_blue",   want.out_blue,   out_data.out_blue);
                    check_field("out_green",  want.out_green,  out_data.out_green);
                    check_field("out_red",    want.out_red,    out_data.out_red);
                    check_field("out_alpha",  want.out_alpha,  out_data.out_alpha);
                    check_field("last_pixel", want.last_pixel, out_data.last_pixel);
                end
            end
        end
    end

    // Output side: raise out_stall at random before each pixel, with calm stretches
    initial
    begin
        int  hold;
        int  served;
        bit  rx_calm;
        out_stall = 1'b0;
        served    = 0;
        rx_calm   = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (served % 48 == 0)
                rx_calm = ($urandom_range(0, 3) == 0);
            hold = rx_calm ? 0 : $urandom_range(0, 3);
            repeat (hold)
            begin
                @(negedge clk);
                out_stall <= 1'b1;
                @(posedge clk);
            end
            @(negedge clk);
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            served++;
        end
    end

    // Stimulus: directed table first, then random phases, one format each
    initial
    begin
        in_item_t blk;
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_wdata      = FMT_DXT1;
        in_valid       = 1'b0;
        in_data        = '0;
        pin_on         = 1'b0;
        pin_bgra       = '0;
        fmt_shadow     = FMT_DXT1;
        tx_calm        = 1'b0;
        mismatch_count = 0;
        blocks_taken   = 0;
        pixels_checked = 0;
        fmt_blocks     = '{0, 0, 0, 0};

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // The first rows rely on the reset format; write only when it changes
        for (int r = 0; r < PLAN_LEN; r++)
        begin
            if (PLAN[r].fmt != fmt_shadow)
                write_format(PLAN[r].fmt);
            blk = '{PLAN[r].lo, PLAN[r].hi, PLAN[r].col, PLAN[r].row};
            send_block(blk, PLAN[r].pinned, PLAN[r].bgra);
        end

        // Visit every format in turn, then random ones
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            write_format(fmt_t'(p < 4 ? p : $urandom_range(0, 3)));
            tx_calm = ($urandom_range(0, 3) == 0);
            repeat (BLOCKS_PER_PHASE)
                send_block(random_block(), 1'b0, 32'h0);
        end

        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
        // Hold a little longer to catch any stray pixel
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Decoded %0d blocks into %0d checked pixels, %0d field mismatches.",
                 blocks_taken, pixels_checked, mismatch_count);
        $display("Blocks per format: DXT1 %0d, DXT3 %0d, DXT5 %0d, two-channel %0d.",
                 fmt_blocks[FMT_DXT1], fmt_blocks[FMT_DXT3], fmt_blocks[FMT_DXT5],
                 fmt_blocks[FMT_BC5]);
        if (mismatch_count == 0 && pending_pixels.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial
    begin
        #2_000_000;
        $display("Timeout with %0d pixels still owed", pending_pixels.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule
